// File: rtl/core/ovc_pkg.sv
// ----------------------------------------------------------------------------
// ovc_pkg
// shared types and constants of the offset-value code stream
// ----------------------------------------------------------------------------
package ovc_pkg;

    localparam int DOMAIN_W = 16;
    localparam int ARITY_W  = 5;
    localparam int OFFSET_W = 5;
    localparam int CODE_W   = 16;
    localparam int SCALE_W  = 14;

    // result queue depth, also the limit on results in flight
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DOMAIN = 2'd0,
        REG_ARITY  = 2'd1,
        REG_ASCEND = 2'd2
    } reg_index_t;

    // live configuration, arity already clamped to the usable range
    typedef struct packed {
        logic [DOMAIN_W-1:0] domain;
        logic [ARITY_W-1:0]  arity;
        logic                ascending;
        logic [SCALE_W-1:0]  scale;
    } cfg_t;

    // offset and value of a finished row, before encoding
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [CODE_W-1:0]   value;
    } pend_t;

    typedef struct packed {
        logic [CODE_W-1:0]   value;
        logic [OFFSET_W-1:0] offset;
        logic [CODE_W-1:0]   code;
    } result_t;

endpackage

// File: rtl/core/ovc_track.sv
// ----------------------------------------------------------------------------
// ovc_track
// column counter, previous-row memory and first-difference tracking
// ----------------------------------------------------------------------------
module ovc_track #(
    parameter int MAX_COLUMNS = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ovc_pkg::cfg_t         cfg,
    input  logic                  in_accept,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  row_end,
    output logic                  pend_valid,
    output ovc_pkg::pend_t        pend
);
    import ovc_pkg::*;

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WIDE  = (VALUE_BITS > CODE_W) ? VALUE_BITS : CODE_W;

    logic [VALUE_BITS-1:0] mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] written_reg;

    logic [IDX_W-1:0]      col_reg, col_next;
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    logic                  seen_reg;
    logic [OFFSET_W-1:0]   fcol_reg;
    logic [VALUE_BITS-1:0] fval_reg;
    logic                  pend_valid_reg;
    pend_t                 pend_reg, pend_next;

    logic                  fwd;
    logic [VALUE_BITS-1:0] prev;
    logic                  hit;
    logic                  row_seen;
    logic [OFFSET_W-1:0]   row_col;
    logic [VALUE_BITS-1:0] row_val;
    logic [OFFSET_W-1:0]   off_sel;
    logic [WIDE-1:0]       val_src, sub_w, msk_w;

    // stage 0: column position and memory read
    assign row_end  = (7'(col_reg) + 7'd1) >= 7'(cfg.arity);
    assign col_next = row_end ? '0 : IDX_W'(col_reg + 1'b1);
    assign fwd      = s1_valid_reg && (s1_idx_reg == col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
        end else begin
            s1_valid_reg <= in_accept;
            if (in_accept) begin
                col_reg <= col_next;
            end
            if (s1_valid_reg) begin
                written_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            mem[s1_idx_reg] <= s1_value_reg;
        end
        // the column written this cycle is forwarded to a read of the same entry
        rd_data_reg  <= fwd ? s1_value_reg : mem[col_reg];
        rd_valid_reg <= fwd | written_reg[col_reg];
        if (in_accept) begin
            s1_idx_reg   <= col_reg;
            s1_value_reg <= in_value;
            s1_last_reg  <= row_end;
        end
    end

    // stage 1: compare and track
    always_comb begin
        prev     = rd_valid_reg ? rd_data_reg : '0;
        hit      = !seen_reg && (prev != s1_value_reg);
        row_seen = seen_reg | hit;
        row_col  = seen_reg ? fcol_reg : OFFSET_W'(s1_idx_reg);
        row_val  = seen_reg ? fval_reg : s1_value_reg;
        off_sel  = row_seen ? row_col : cfg.arity;
        val_src  = row_seen ? WIDE'(row_val) : WIDE'(cfg.domain);
        sub_w    = WIDE'(cfg.domain) - val_src;
        msk_w    = sub_w;
        for (int i = VALUE_BITS; i < WIDE; i++) begin
            msk_w[i] = 1'b0;
        end
        if (cfg.ascending) begin
            pend_next.offset = OFFSET_W'(cfg.arity - off_sel);
            pend_next.value  = CODE_W'(val_src);
        end else begin
            pend_next.offset = off_sel;
            pend_next.value  = CODE_W'(msk_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            fcol_reg       <= '0;
            fval_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg) begin
                if (s1_last_reg) begin
                    seen_reg <= 1'b0;
                    fcol_reg <= '0;
                    fval_reg <= '0;
                end else begin
                    seen_reg <= row_seen;
                    fcol_reg <= row_col;
                    fval_reg <= row_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_last_reg) begin
            pend_reg <= pend_next;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

// File: rtl/core/ovc_encode.sv
// ----------------------------------------------------------------------------
// ovc_encode
// forms the code word: offset times decade scale plus value
// ----------------------------------------------------------------------------
module ovc_encode (
    input  ovc_pkg::pend_t                 pend,
    input  logic [ovc_pkg::SCALE_W-1:0]    scale,
    output ovc_pkg::result_t               result
);
    import ovc_pkg::*;

    logic [19:0] sum;

    always_comb begin
        sum           = 20'(pend.offset) * 20'(scale) + 20'(pend.value);
        result.code   = sum[CODE_W-1:0];
        result.offset = pend.offset;
        result.value  = pend.value;
    end

endmodule

// File: rtl/core/ovc_result_fifo.sv
// ----------------------------------------------------------------------------
// ovc_result_fifo
// small register queue between the encoder and the result channel
// ----------------------------------------------------------------------------
module ovc_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ovc_pkg::result_t  push_data,
    input  logic              pop,
    output logic              head_valid,
    output ovc_pkg::result_t  head_data
);
    import ovc_pkg::*;

    result_t               entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= RES_PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= RES_PTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= RES_CNT_W'(count_reg + RES_CNT_W'(push) - RES_CNT_W'(pop));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

endmodule

// File: rtl/core/offset_value_code_stream.sv
// a row's code word reaches m_axis through the stage-1 registers (memory read), the pending
// result register (compare and select) and the result queue (encode on the way in)
// throughput: one column word per cycle; the last column of a row waits only while four
// results are outstanding in the pipeline and result queue
// reset: config returns to its defaults and the previous row reads as zeros at once
// through per-column written bits, with no clearing pass
// ----------------------------------------------------------------------------
// offset_value_code_stream
// turns a stream of sorted rows, one column per word, into offset-value codes
// against the previous row held in a small column memory
// ----------------------------------------------------------------------------
module offset_value_code_stream #(
    parameter int MAX_COLUMNS = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,

    // column stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column_value
    input  logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,

    // code stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // code_word, code_offset, code_value, zero pad
    output logic [39:0] m_axis_tdata
);
    import ovc_pkg::*;

    // arity clamp: the register field tops out at 31
    localparam int ARITY_CAP = (MAX_COLUMNS > 31) ? 31 : MAX_COLUMNS;

    // largest power of ten not above the domain, one for a zero domain
    function automatic logic [SCALE_W-1:0] decade_scale(input logic [DOMAIN_W-1:0] d);
        logic [SCALE_W-1:0] p;
        if (d >= 16'd10000) p = 14'd10000;
        else if (d >= 16'd1000) p = 14'd1000;
        else if (d >= 16'd100) p = 14'd100;
        else if (d >= 16'd10) p = 14'd10;
        else p = 14'd1;
        return p;
    endfunction

    // configuration registers
    logic [DOMAIN_W-1:0] domain_reg;
    logic [ARITY_W-1:0]  arity_reg;
    logic                ascend_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [ARITY_W-1:0]  arity_eff;
    cfg_t                cfg;

    // handshake and result credit
    logic                 s_accept, m_accept, row_end, row_accept;
    logic [RES_CNT_W-1:0] credit_reg, credit_next;

    pend_t                pend;
    logic                 pend_valid;
    result_t              enc_result, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            domain_reg <= 16'd100;
            arity_reg  <= 5'd4;
            ascend_reg <= 1'b1;
            scale_reg  <= 14'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_DOMAIN: begin
                    domain_reg <= cfg_wr_data;
                    scale_reg  <= decade_scale(cfg_wr_data);
                end
                REG_ARITY:  arity_reg  <= cfg_wr_data[ARITY_W-1:0];
                REG_ASCEND: ascend_reg <= cfg_wr_data[0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    // zero arity acts as one, too large acts as the column capacity
    always_comb begin
        if (arity_reg == '0) arity_eff = 5'd1;
        else if (arity_reg > ARITY_W'(ARITY_CAP)) arity_eff = ARITY_W'(ARITY_CAP);
        else arity_eff = arity_reg;
        cfg.domain    = domain_reg;
        cfg.arity     = arity_eff;
        cfg.ascending = ascend_reg;
        cfg.scale     = scale_reg;
    end

    // a row-ending word needs a free slot; other columns always go through
    assign s_axis_tready = !row_end || (credit_reg < RES_CNT_W'(RES_DEPTH));
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign row_accept    = s_accept && row_end;
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign credit_next   = RES_CNT_W'(credit_reg + RES_CNT_W'(row_accept)
                                      - RES_CNT_W'(m_accept));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // column counter, previous row memory, difference tracking
    ovc_track #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_accept  (s_accept),
        .in_value   (s_axis_tdata[VALUE_BITS-1:0]),
        .row_end    (row_end),
        .pend_valid (pend_valid),
        .pend       (pend)
    );

    // code word math
    ovc_encode u_encode (
        .pend   (pend),
        .scale  (scale_reg),
        .result (enc_result)
    );

    // results wait here for the downstream side
    ovc_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (pend_valid),
        .push_data  (enc_result),
        .pop        (m_accept),
        .head_valid (m_axis_tvalid),
        .head_data  (head)
    );

    assign m_axis_tdata = {3'b000, head.value, head.offset, head.code};

    // results in flight never exceed the queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result credit above queue depth");

    // a shown result is always counted
    a_valid_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (credit_reg != '0))
        else $error("result shown with no credit");

    // a row end accepted without a result taken raises the count by one
    a_credit_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_accept && !m_accept) |=> (credit_reg == RES_CNT_W'($past(credit_reg) + 1'b1)))
        else $error("credit did not follow a row end");

    // input stalls only when the queue budget is spent
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && !s_axis_tready) |-> (credit_reg == RES_CNT_W'(RES_DEPTH)))
        else $error("input stalled with free result slots");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the offset-value code stream: rows of column words
// go in, every code word coming out is checked against a cycle-free model of
// the previous-row compare kept in this bench
// ----------------------------------------------------------------------------
module tb_top;
    import ovc_pkg::*;

    localparam int LATENCY     = 3;        // last column to code word on m_axis
    localparam int CYCLE_LIMIT = 400000;   // watchdog, well above the slowest run
    localparam int NUM_COLS    = 16;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_wr_index  = '0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // column_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // code_word, code_offset, code_value, zero pad

    offset_value_code_stream u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // shadow of the block: config and previous-row state
    // ------------------------------------------------------------------
    logic [15:0] cfg_domain = 16'd100;
    logic [4:0]  cfg_arity  = 5'd4;
    logic        cfg_ascend = 1'b1;

    logic [15:0] prior_row [NUM_COLS];
    int          col_pos   = 0;
    bit          diff_seen = 1'b0;
    int          diff_col  = 0;
    logic [15:0] diff_val  = '0;

    // code words still owed by the block, oldest first
    result_t     code_expect_q [$];

    int send_idle_pct   = 27;
    int recv_idle_pct   = 80;
    int ready_hold_req  = 0;
    int ready_hold_left = 0;
    int fault_count     = 0;
    int cycle_count     = 0;

    initial begin
        for (int i = 0; i < NUM_COLS; i++) prior_row[i] = '0;
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // arity 0 behaves as 1, anything past the column store as the full store
    function automatic int eff_arity();
        if (cfg_arity == 0) return 1;
        if (cfg_arity > NUM_COLS) return NUM_COLS;
        return cfg_arity;
    endfunction

    // largest power of ten not above the domain, 1 for a zero domain
    function automatic int unsigned decade_floor(logic [15:0] d);
        int unsigned p;
        p = 1;
        while (d != 0 && p * 10 <= d) p = p * 10;
        return p;
    endfunction

    // advance the shadow by one accepted column word, queue a code word at row end
    task automatic predict_column(input logic [15:0] v);
        int          idx;
        int          arity;
        int          off;
        int unsigned val;
        result_t     r;
        idx   = col_pos % NUM_COLS;
        arity = eff_arity();
        if (!diff_seen && prior_row[idx] != v) begin
            diff_seen = 1'b1;
            diff_col  = idx;
            diff_val  = v;
        end
        prior_row[idx] = v;
        if (idx + 1 < arity) begin
            col_pos = (idx + 1) & 'h1F;
            return;
        end
        if (diff_seen) begin
            off = diff_col;
            val = diff_val;
        end else begin
            off = arity;
            val = cfg_domain;
        end
        // ascending flips the offset, descending flips the value
        if (cfg_ascend) off = (arity - off) & 'h1F;
        else val = (cfg_domain - val) & 'hFFFF;
        r.offset = off[4:0];
        r.value  = val[15:0];
        r.code   = 16'((off * decade_floor(cfg_domain) + val) & 'hFFFF);
        code_expect_q.push_back(r);
        col_pos   = 0;
        diff_seen = 1'b0;
        diff_col  = 0;
        diff_val  = '0;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one column word, random gaps first, hold it until taken
    task automatic send_column(input logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge aclk); while (!s_axis_tready);
        predict_column(v);
    endtask

    // config write, only called with the block idle
    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        case (idx)
            REG_DOMAIN: cfg_domain = data;
            REG_ARITY:  cfg_arity  = data[4:0];
            REG_ASCEND: cfg_ascend = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] dom, input logic [4:0] ar, input bit asc);
        write_reg(REG_DOMAIN, dom);
        write_reg(REG_ARITY, {11'd0, ar});
        write_reg(REG_ASCEND, {15'd0, asc});
    endtask

    // drain every owed code word, then let a partial row settle past the pipe
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (code_expect_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // a column word either repeating the previous row or fresh content
    task automatic send_next_column(input bit keep);
        logic [15:0] v;
        if (keep) begin
            v = prior_row[col_pos % NUM_COLS];
        end else begin
            case ($urandom_range(3))
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(cfg_domain));
                2: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: v = prior_row[col_pos % NUM_COLS] + 16'($urandom_range(1, 3));
            endcase
        end
        send_column(v);
    endtask

    // finish the current row: a random prefix equal to the previous row
    task automatic send_row(output int n);
        int k;
        n = (col_pos < eff_arity()) ? eff_arity() - col_pos : 1;
        k = $urandom_range(n);
        for (int i = 0; i < n; i++) send_next_column(i < k);
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    // random ready, or a long hold-off when a test asks for one
    always @(posedge aclk) begin
        if (ready_hold_req != 0) begin
            ready_hold_left = ready_hold_req;
            ready_hold_req  = 0;
        end
        if (ready_hold_left > 0) begin
            ready_hold_left = ready_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic log_fault(input string msg);
        if (fault_count < 10) $display("mismatch: %s", msg);
        fault_count++;
    endtask

    always @(posedge aclk) begin : check_codes
        result_t want;
        result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[36:0];
            if (code_expect_q.size() == 0) begin
                log_fault($sformatf("unexpected code word code=%0d offset=%0d value=%0d",
                                    got.code, got.offset, got.value));
            end else begin
                want = code_expect_q.pop_front();
                if (got.code !== want.code || got.offset !== want.offset ||
                    got.value !== want.value)
                    log_fault($sformatf({"expected code=%0d offset=%0d value=%0d, ",
                                         "actual code=%0d offset=%0d value=%0d"},
                                        want.code, want.offset, want.value,
                                        got.code, got.offset, got.value));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults after reset, first row against the cleared store
    task automatic test_reset_defaults();
        send_column(16'd0);
        send_column(16'd0);
        send_column(16'd0);
        send_column(16'd0);
        wait_idle();
    endtask

    // arity past the store acts as the full store, row hits all value bits
    task automatic test_arity_clamp();
        logic [15:0] pat [4];
        pat = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A};
        set_config(16'hFFFF, 5'd31, 1'b0);
        for (int i = 0; i < NUM_COLS; i++) send_column(pat[i % 4]);
        wait_idle();
    endtask

    // arity 0 acts as one column per row
    task automatic test_arity_zero();
        set_config(16'd1000, 5'd0, 1'b1);
        send_column(16'd1234);
        wait_idle();
    endtask

    // lowering the arity mid-row ends the row, offset wraps in 5 bits
    task automatic test_midrow_arity();
        set_config(16'd100, 5'd4, 1'b1);
        send_column(prior_row[0]);
        send_column(prior_row[1]);
        send_column(prior_row[2] ^ 16'h0001);
        wait_idle();
        write_reg(REG_ARITY, 16'd1);
        send_column(16'd42);
        wait_idle();
    endtask

    // descending with a value above the domain wraps, then an equal row
    task automatic test_descending_wrap();
        set_config(16'd10, 5'd1, 1'b0);
        send_column(16'd60000);
        send_column(16'd60000);
        wait_idle();
    endtask

    // zero domain scales the offset by one
    task automatic test_zero_domain();
        set_config(16'd0, 5'd1, 1'b1);
        send_column(16'd7);
        wait_idle();
    endtask

    // receiver holds off while single-column rows keep coming: input must stall
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        set_config(16'd1000, 5'd1, 1'b1);
        ready_hold_req = 300;
        repeat (40) send_next_column($urandom_range(3) == 0);
        send_idle_pct = saved_idle;
        wait_idle();
    endtask

    // random settings between batches of well-formed rows, some cut short
    task automatic test_random_rows(input int n_items);
        int sent;
        int n;
        int arity;
        logic [15:0] dom;
        logic [4:0]  ar;
        sent = 0;
        while (sent < n_items) begin
            wait_idle();
            case ($urandom_range(7))
                0: dom = 16'd0;
                1: dom = 16'd1;
                2: dom = 16'hFFFF;
                3: dom = 16'd9999;
                4: dom = 16'($urandom_range(1, 200));
                5: begin
                    case ($urandom_range(3))
                        0: dom = 16'd10;
                        1: dom = 16'd100;
                        2: dom = 16'd1000;
                        default: dom = 16'd10000;
                    endcase
                end
                default: dom = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0: ar = 5'd0;
                1: ar = 5'($urandom_range(17, 31));
                2, 3: ar = 5'($urandom_range(1, 16));
                default: ar = 5'($urandom_range(1, 6));
            endcase
            set_config(dom, ar, 1'($urandom_range(1)));
            repeat ($urandom_range(2, 8)) begin
                send_row(n);
                sent += n;
            end
            // broken row: stop mid-row so the next setting lands inside it
            arity = eff_arity();
            if ($urandom_range(4) == 0 && arity > 1) begin
                repeat ($urandom_range(1, arity - 1)) begin
                    send_next_column($urandom_range(1));
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_arity_clamp();
        test_arity_zero();
        test_midrow_arity();
        test_descending_wrap();
        test_zero_domain();
        test_backpressure();

        test_random_rows(200);
        send_idle_pct = 80;
        recv_idle_pct = 27;
        test_random_rows(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_rows(200);

        wait_idle();
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
